@@ hw/rtl/gpb_pkg.sv @@
// gpb_pkg: shared types, field widths and codes of the glyph-to-pixel blitter.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package gpb_pkg;

  // Font geometry and defaults for the top-level parameter
  localparam int unsigned GLYPH_SIZE        = 8;
  localparam int unsigned GLYPH_COUNT       = 256;
  localparam int unsigned MAX_SCREEN_WIDTH  = 1024;
  localparam int unsigned MAX_SCREEN_HEIGHT = 1024;

  // Field widths
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned BITS_W  = 8;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned ADDR_W  = 20;

  // Signed coordinate with one guard bit for the glyph offset
  localparam int unsigned COORD_W = POS_W + 1;
  // Compare width for saturating the screen size against its maximum
  localparam int unsigned SAT_W   = 13;

  // Register file port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_SIZE - 1);

  // Register reset values
  localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH  = DIM_W'(320);
  localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT = DIM_W'(200);
  localparam logic [COLOR_W-1:0] RST_TEXT_COLOR    = COLOR_W'(7);

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_DRAW = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_TEXT_COLOR    = 2'd2
  } reg_idx_t;

  // Effective (saturated) configuration handed to the draw engine
  typedef struct packed {
    logic [DIM_W-1:0]   screen_width;
    logic [DIM_W-1:0]   screen_height;
    logic [COLOR_W-1:0] text_color;
  } gpb_cfg_t;

endpackage

@@ hw/rtl/gpb_ifs.sv @@
// gpb_ifs: valid/ready channel interfaces for draw/load items and pixel results.
// Depends on gpb_pkg for field widths.
`timescale 1ns / 1ps

interface gpb_in_if;
  import gpb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [CODE_W-1:0]        char_code;
  logic [ROW_W-1:0]         glyph_row;
  logic [BITS_W-1:0]        row_bits;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic                     fill_background;

  modport source (
    output valid, action, char_code, glyph_row, row_bits, pos_x, pos_y, fill_background,
    input  ready
  );
  modport sink (
    input  valid, action, char_code, glyph_row, row_bits, pos_x, pos_y, fill_background,
    output ready
  );
endinterface

interface gpb_out_if;
  import gpb_pkg::*;

  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;
  logic               last;

  modport source (
    output valid, write_enable, pixel_address, pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, write_enable, pixel_address, pixel_color, last,
    output ready
  );
endinterface

@@ hw/rtl/gpb_cfg_regs.sv @@
// gpb_cfg_regs: APB register file for screen size and text color, with
// saturation of the screen size. Depends on gpb_pkg.
`timescale 1ns / 1ps

module gpb_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gpb_pkg::PADDR_W-1:0]  paddr,
  input  logic [gpb_pkg::PDATA_W-1:0]  pwdata,
  output logic [gpb_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output gpb_pkg::gpb_cfg_t            cfg
);
  import gpb_pkg::*;

  logic [DIM_W-1:0]   width_r,  width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic [COLOR_W-1:0] color_r,  color_nxt;
  reg_idx_t           reg_idx;
  logic               wr_fire;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  // Register write decode
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    color_nxt  = color_r;
    if (wr_fire) begin
      unique case (reg_idx)
        REG_SCREEN_WIDTH:  width_nxt  = pwdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: height_nxt = pwdata[DIM_W-1:0];
        REG_TEXT_COLOR:    color_nxt  = pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_SCREEN_WIDTH;
      height_r <= RST_SCREEN_HEIGHT;
      color_r  <= RST_TEXT_COLOR;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      color_r  <= color_nxt;
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_SCREEN_WIDTH:  prdata = PDATA_W'(width_r);
      REG_SCREEN_HEIGHT: prdata = PDATA_W'(height_r);
      REG_TEXT_COLOR:    prdata = PDATA_W'(color_r);
      default:           prdata = '0;
    endcase
  end

  // Clamp the screen size to what the framebuffer supports
  always_comb begin
    cfg.screen_width  = (SAT_W'(width_r) > SAT_W'(MAX_SCREEN_WIDTH))
                        ? DIM_W'(MAX_SCREEN_WIDTH) : width_r;
    cfg.screen_height = (SAT_W'(height_r) > SAT_W'(MAX_SCREEN_HEIGHT))
                        ? DIM_W'(MAX_SCREEN_HEIGHT) : height_r;
    cfg.text_color    = color_r;
  end

endmodule

@@ hw/rtl/gpb_font_ram.sv @@
// gpb_font_ram: font memory, one byte per glyph row, one write and one
// registered read port. Depends on gpb_pkg.
`timescale 1ns / 1ps

module gpb_font_ram #(
  parameter int unsigned GLYPH_COUNT = gpb_pkg::GLYPH_COUNT,
  localparam int unsigned FONT_DEPTH = GLYPH_COUNT * gpb_pkg::GLYPH_SIZE,
  localparam int unsigned FONT_AW    = $clog2(FONT_DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [FONT_AW-1:0]          wr_addr,
  input  logic [gpb_pkg::BITS_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [FONT_AW-1:0]          rd_addr,
  output logic [gpb_pkg::BITS_W-1:0]  rd_data
);
  import gpb_pkg::*;

  logic [BITS_W-1:0] mem [FONT_DEPTH];
  logic [BITS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/gpb_draw_seq.sv @@
// gpb_draw_seq: item intake, font row loads, and the row/column scan that
// turns one glyph into pixel results through a pending and an output register.
// Depends on gpb_pkg and gpb_ifs.
`timescale 1ns / 1ps

module gpb_draw_seq #(
  parameter int unsigned GLYPH_COUNT = gpb_pkg::GLYPH_COUNT,
  localparam int unsigned FONT_AW    = $clog2(GLYPH_COUNT * gpb_pkg::GLYPH_SIZE)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gpb_in_if.sink                      in_ch,
  gpb_out_if.source                   out_ch,
  input  gpb_pkg::gpb_cfg_t           cfg,
  output logic                        font_we,
  output logic [FONT_AW-1:0]          font_waddr,
  output logic [gpb_pkg::BITS_W-1:0]  font_wdata,
  output logic                        font_re,
  output logic [FONT_AW-1:0]          font_raddr,
  input  logic [gpb_pkg::BITS_W-1:0]  font_rdata
);
  import gpb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic                fill_r, fill_nxt;
  logic [COORD_W-1:0]  px_r, px_nxt;
  logic [COORD_W-1:0]  xx_r, xx_nxt;
  logic [COORD_W-1:0]  yy_r, yy_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [ROW_W-1:0]    col_r, col_nxt;
  logic [ADDR_W-1:0]   row_base_r, row_base_nxt;
  logic                y_ok_r, y_ok_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [ADDR_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic [COLOR_W-1:0]  pend_color_r, pend_color_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_we_r, out_we_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [COLOR_W-1:0]  out_color_r, out_color_nxt;
  logic                out_last_r, out_last_nxt;

  logic                        in_fire;
  logic                        code_ok;
  logic [CODE_W+ROW_W-1:0]     wr_full;
  logic [CODE_W+ROW_W-1:0]     rd_full;
  logic [2*DIM_W-1:0]          prod;
  logic                        bit_set;
  logic                        x_ok;
  logic                        hit;
  logic [ADDR_W-1:0]           cand_addr;
  logic [COLOR_W-1:0]          cand_color;
  logic                        out_free;
  logic                        scan_step;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign code_ok     = {1'b0, in_ch.char_code} < (CODE_W + 1)'(GLYPH_COUNT);

  // Font loads go straight into the memory
  assign wr_full    = {in_ch.char_code, in_ch.glyph_row};
  assign font_we    = in_fire && (in_ch.action == ACT_LOAD) && code_ok;
  assign font_waddr = wr_full[FONT_AW-1:0];
  assign font_wdata = in_ch.row_bits;

  // One row read per glyph row
  assign rd_full    = {code_r, row_r};
  assign font_re    = (state_r == ST_FETCH);
  assign font_raddr = rd_full[FONT_AW-1:0];

  // Line base address, registered before the per-pixel add
  assign prod = yy_r[DIM_W-1:0] * cfg.screen_width;

  // Current pixel candidate
  assign bit_set    = font_rdata[col_r];
  assign x_ok       = !xx_r[COORD_W-1] && (xx_r[DIM_W-1:0] < cfg.screen_width);
  assign hit        = (bit_set || fill_r) && y_ok_r && x_ok;
  assign cand_addr  = row_base_r + ADDR_W'(xx_r[DIM_W-1:0]);
  assign cand_color = bit_set ? cfg.text_color : '0;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign scan_step = (state_r == ST_SCAN) && (!hit || !pend_valid_r || out_free);

  // Sequencer and result registers
  always_comb begin
    state_nxt      = state_r;
    code_nxt       = code_r;
    fill_nxt       = fill_r;
    px_nxt         = px_r;
    xx_nxt         = xx_r;
    yy_nxt         = yy_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    row_base_nxt   = row_base_r;
    y_ok_nxt       = y_ok_r;
    pend_valid_nxt = pend_valid_r;
    pend_addr_nxt  = pend_addr_r;
    pend_color_nxt = pend_color_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_we_nxt     = out_we_r;
    out_addr_nxt   = out_addr_r;
    out_color_nxt  = out_color_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.action == ACT_DRAW)) begin
          code_nxt       = in_ch.char_code;
          fill_nxt       = in_ch.fill_background;
          px_nxt         = {in_ch.pos_x[POS_W-1], in_ch.pos_x};
          xx_nxt         = {in_ch.pos_x[POS_W-1], in_ch.pos_x};
          yy_nxt         = {in_ch.pos_y[POS_W-1], in_ch.pos_y};
          row_nxt        = '0;
          col_nxt        = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = code_ok ? ST_FETCH : ST_FLUSH;
        end
      end

      ST_FETCH: begin
        row_base_nxt = prod[ADDR_W-1:0];
        y_ok_nxt     = !yy_r[COORD_W-1] && (yy_r[DIM_W-1:0] < cfg.screen_height);
        state_nxt    = ST_SCAN;
      end

      ST_SCAN: begin
        if (scan_step) begin
          if (hit) begin
            // the previous pixel is known not to be last: send it on
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_we_nxt    = 1'b1;
              out_addr_nxt  = pend_addr_r;
              out_color_nxt = pend_color_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_addr_nxt  = cand_addr;
            pend_color_nxt = cand_color;
          end
          col_nxt = col_r + ROW_W'(1);
          xx_nxt  = xx_r + COORD_W'(1);
          if (col_r == ROW_LAST) begin
            xx_nxt    = px_r;
            yy_nxt    = yy_r + COORD_W'(1);
            row_nxt   = row_r + ROW_W'(1);
            state_nxt = (row_r == ROW_LAST) ? ST_FLUSH : ST_FETCH;
          end
        end
      end

      ST_FLUSH: begin
        // final pixel carries last; a draw with no pixel gives an empty result
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_we_nxt     = pend_valid_r;
          out_addr_nxt   = pend_valid_r ? pend_addr_r : '0;
          out_color_nxt  = pend_valid_r ? pend_color_r : '0;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    fill_r       <= fill_nxt;
    px_r         <= px_nxt;
    xx_r         <= xx_nxt;
    yy_r         <= yy_nxt;
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    row_base_r   <= row_base_nxt;
    y_ok_r       <= y_ok_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_color_r <= pend_color_nxt;
    out_we_r     <= out_we_nxt;
    out_addr_r   <= out_addr_nxt;
    out_color_r  <= out_color_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.write_enable  = out_we_r;
  assign out_ch.pixel_address = out_addr_r;
  assign out_ch.pixel_color   = out_color_r;
  assign out_ch.last          = out_last_r;

  // Checks
  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.action == ACT_LOAD) |=> state_r == ST_IDLE)
    else $error("load item started the draw engine");

  a_draw_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.action == ACT_DRAW) |=> state_r != ST_IDLE)
    else $error("draw item not taken up by the engine");

  a_no_pending_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_valid_r)
    else $error("pixel left pending after a draw ended");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_we_r |-> out_last_r)
    else $error("non-write result without last");

endmodule

@@ hw/rtl/glyph_to_pixel_blitter.sv @@
// Glyph-to-pixel blitter: a load item stores one 8-bit font row. A draw item
// is taken in the idle state, then its glyph is scanned with one font-memory
// read per row and, while the output does not stall, one column per cycle;
// a closing state then sends the final result. A character code outside the
// font goes from intake straight to the closing state. The single registered
// read port of the font memory and the output register, one pixel per cycle
// when results are taken at once, pace the scan; output stalls hold it.
// Each written pixel comes out as address line*screen_width+column and a
// color; the final result of a draw has last set, and a draw that writes
// nothing gives one result with write_enable low. The font memory has no
// reset: glyph rows must be loaded before they are drawn.
// Depends on gpb_pkg, gpb_ifs, gpb_cfg_regs, gpb_font_ram, gpb_draw_seq.
`timescale 1ns / 1ps

module glyph_to_pixel_blitter #(
  parameter int unsigned GLYPH_COUNT = gpb_pkg::GLYPH_COUNT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  gpb_in_if.sink                       in_ch,
  gpb_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gpb_pkg::PADDR_W-1:0]  paddr,
  input  logic [gpb_pkg::PDATA_W-1:0]  pwdata,
  output logic [gpb_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import gpb_pkg::*;

  localparam int unsigned FONT_AW = $clog2(GLYPH_COUNT * GLYPH_SIZE);

  gpb_cfg_t            cfg;
  logic                font_we;
  logic [FONT_AW-1:0]  font_waddr;
  logic [BITS_W-1:0]   font_wdata;
  logic                font_re;
  logic [FONT_AW-1:0]  font_raddr;
  logic [BITS_W-1:0]   font_rdata;

  gpb_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gpb_font_ram #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_font_ram (
    .clk     (clk),
    .wr_en   (font_we),
    .wr_addr (font_waddr),
    .wr_data (font_wdata),
    .rd_en   (font_re),
    .rd_addr (font_raddr),
    .rd_data (font_rdata)
  );

  gpb_draw_seq #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_draw_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg        (cfg),
    .font_we    (font_we),
    .font_waddr (font_waddr),
    .font_wdata (font_wdata),
    .font_re    (font_re),
    .font_raddr (font_raddr),
    .font_rdata (font_rdata)
  );

endmodule

@@ sim/glyph_to_pixel_blitter_tb.sv @@
// Self-checking testbench for glyph_to_pixel_blitter: drives load and draw items,
// programs the screen registers over APB and checks every pixel result.
// Depends on gpb_pkg, gpb_ifs and the blitter RTL.
`timescale 1ns / 1ps

module glyph_to_pixel_blitter_tb;
  import gpb_pkg::*;

  localparam int DRAW_CYCLES   = 74;
  localparam int SETTLE_CYCLES = DRAW_CYCLES + 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int FONT_ROWS     = GLYPH_COUNT * GLYPH_SIZE;

  typedef struct {
    action_t                 act;
    logic [CODE_W-1:0]       code;
    logic [ROW_W-1:0]        row;
    logic [BITS_W-1:0]       bits;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    fill;
  } glyph_cmd_t;

  typedef struct {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_wr_t;

  typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  gpb_in_if  in_ch ();
  gpb_out_if out_ch ();

  glyph_to_pixel_blitter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the font and the screen registers
  logic [BITS_W-1:0]  font_rows [FONT_ROWS];
  bit                 row_loaded [FONT_ROWS];
  bit                 glyph_ready [GLYPH_COUNT];
  logic [CODE_W-1:0]  drawable [$];
  logic [DIM_W-1:0]   scr_width;
  logic [DIM_W-1:0]   scr_height;
  logic [COLOR_W-1:0] ink_color;

  pixel_wr_t pixel_q [$];
  int        errors = 0;
  bit        gaps_on = 1'b1;
  int        burst_left = 1;
  int        hold_reqs = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: stall pattern changes every so often; a hold request stalls it long
  initial begin
    rx_mode_t rx_mode;
    int       mode_left;
    int       hold_left;
    int       hold_seen;
    int       stall_run;
    int       rx_cyc;
    bit       rdy;
    rx_mode   = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    stall_run = 0;
    rx_cyc    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        case (rx_mode)
          RX_FREE:     rdy = 1'b1;
          RX_RANDOM:   rdy = (stall_run < 3) ? 1'($urandom_range(0, 1)) : 1'b1;
          default:     rdy = (rx_cyc % 4) != 3;
        endcase
        stall_run = rdy ? 0 : stall_run + 1;
        out_ch.ready <= rdy;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compare each accepted pixel result with the oldest expected one
  always @(posedge clk) begin
    pixel_wr_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel result: address %0d", out_ch.pixel_address);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        check_field("write_enable", 32'(want.we), 32'(out_ch.write_enable));
        check_field("pixel_address", 32'(want.addr), 32'(out_ch.pixel_address));
        check_field("pixel_color", 32'(want.color), 32'(out_ch.pixel_color));
        check_field("last", 32'(want.last), 32'(out_ch.last));
      end
    end
  end

  // Update the font shadow for a load, or expand a draw into expected pixel writes
  function automatic void predict_item(glyph_cmd_t cmd);
    int               base;
    int               w;
    int               h;
    int               px;
    int               py;
    int               x;
    int               y;
    bit               on;
    bit               all_rows;
    logic [BITS_W-1:0] rb;
    pixel_wr_t        pw;
    base = int'(cmd.code) * GLYPH_SIZE;
    if (cmd.act == ACT_LOAD) begin
      if (int'(cmd.code) < GLYPH_COUNT) begin
        font_rows[base + int'(cmd.row)]  = cmd.bits;
        row_loaded[base + int'(cmd.row)] = 1'b1;
        all_rows = 1'b1;
        for (int r = 0; r < GLYPH_SIZE; r++) all_rows &= row_loaded[base + r];
        if (all_rows && !glyph_ready[cmd.code]) begin
          glyph_ready[cmd.code] = 1'b1;
          drawable.push_back(cmd.code);
        end
      end
      return;
    end
    w  = (scr_width > MAX_SCREEN_WIDTH) ? MAX_SCREEN_WIDTH : int'(scr_width);
    h  = (scr_height > MAX_SCREEN_HEIGHT) ? MAX_SCREEN_HEIGHT : int'(scr_height);
    px = cmd.pos_x;
    py = cmd.pos_y;
    pw.last = 1'b0;
    pw.we   = 1'b1;
    if (int'(cmd.code) < GLYPH_COUNT) begin
      for (int r = 0; r < GLYPH_SIZE; r++) begin
        rb = font_rows[base + r];
        y  = py + r;
        for (int c = 0; c < GLYPH_SIZE; c++) begin
          x  = px + c;
          on = rb[c];
          if ((on || cmd.fill) && x >= 0 && x < w && y >= 0 && y < h) begin
            pw.addr  = ADDR_W'(y * w + x);
            pw.color = on ? ink_color : '0;
            pixel_q.push_back(pw);
          end
        end
      end
    end
    // nothing visible: a single disabled write closes the draw
    if (pixel_q.size() == 0 || pixel_q[pixel_q.size()-1].last) begin
      pw = '{we: 1'b0, addr: '0, color: '0, last: 1'b1};
      pixel_q.push_back(pw);
    end else begin
      pixel_q[pixel_q.size()-1].last = 1'b1;
    end
  endfunction

  // Offer one item, wait for the handshake, then maybe pause the burst
  task automatic send_item(glyph_cmd_t cmd);
    in_ch.valid           <= 1'b1;
    in_ch.action          <= cmd.act;
    in_ch.char_code       <= cmd.code;
    in_ch.glyph_row       <= cmd.row;
    in_ch.row_bits        <= cmd.bits;
    in_ch.pos_x           <= cmd.pos_x;
    in_ch.pos_y           <= cmd.pos_y;
    in_ch.fill_background <= cmd.fill;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_item(cmd);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_ch.valid <= 1'b0;
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(20, 100)) @(posedge clk);
        else repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      end
    end
  endtask

  function automatic glyph_cmd_t make_load(logic [CODE_W-1:0] code, logic [ROW_W-1:0] row,
                                           logic [BITS_W-1:0] bits);
    glyph_cmd_t cmd;
    cmd.act   = ACT_LOAD;
    cmd.code  = code;
    cmd.row   = row;
    cmd.bits  = bits;
    cmd.pos_x = POS_W'($urandom);
    cmd.pos_y = POS_W'($urandom);
    cmd.fill  = 1'($urandom);
    return cmd;
  endfunction

  function automatic glyph_cmd_t make_draw(logic [CODE_W-1:0] code, int x, int y, logic fill);
    glyph_cmd_t cmd;
    cmd.act   = ACT_DRAW;
    cmd.code  = code;
    cmd.row   = ROW_W'($urandom);
    cmd.bits  = BITS_W'($urandom);
    cmd.pos_x = POS_W'(x);
    cmd.pos_y = POS_W'(y);
    cmd.fill  = fill;
    return cmd;
  endfunction

  function automatic logic [BITS_W-1:0] random_row();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return BITS_W'($urandom);
    endcase
  endfunction

  // Mostly around the visible area so clipping at every edge shows up
  function automatic int pick_pos(logic [DIM_W-1:0] dim, int max_dim);
    int extent;
    int v;
    extent = (dim > max_dim) ? max_dim : int'(dim);
    if ($urandom_range(0, 9) < 7) begin
      v = int'($urandom_range(0, extent + 8)) - 8;
      if (v > 1023) v = 1023;
    end else begin
      v = int'($urandom_range(0, 2047)) - 1024;
    end
    return v;
  endfunction

  task automatic random_draw();
    logic [CODE_W-1:0] code;
    code = drawable[$urandom_range(0, drawable.size() - 1)];
    send_item(make_draw(code, pick_pos(scr_width, MAX_SCREEN_WIDTH),
                        pick_pos(scr_height, MAX_SCREEN_HEIGHT), 1'($urandom)));
  endtask

  // Drop valid, let every expected pixel arrive, then give the block time to settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register, then the bus is left idle
  task automatic set_register(reg_idx_t idx, logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_SCREEN_WIDTH:  begin scr_width  = value[DIM_W-1:0];   want = 32'(scr_width);  end
      REG_SCREEN_HEIGHT: begin scr_height = value[DIM_W-1:0];   want = 32'(scr_height); end
      default:           begin ink_color  = value[COLOR_W-1:0]; want = 32'(ink_color);  end
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    check_field(idx.name(), want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_screen(int w, int h, int color);
    wait_idle();
    set_register(REG_SCREEN_WIDTH, PDATA_W'(w));
    set_register(REG_SCREEN_HEIGHT, PDATA_W'(h));
    set_register(REG_TEXT_COLOR, PDATA_W'(color));
  endtask

  // Load glyphs 0 and 255, then draw them at the corners, edges and off screen
  task automatic test_directed_glyphs();
    logic [BITS_W-1:0] pattern [GLYPH_SIZE] = '{8'hFF, 8'h00, 8'h81, 8'h01,
                                                8'h80, 8'hAA, 8'h55, 8'h3C};
    for (int r = 0; r < GLYPH_SIZE; r++) send_item(make_load(8'd0, ROW_W'(r), pattern[r]));
    for (int r = 0; r < GLYPH_SIZE; r++) send_item(make_load(8'd255, ROW_W'(r), random_row()));
    send_item(make_draw(8'd0, 0, 0, 1'b0));
    send_item(make_draw(8'd0, 0, 0, 1'b1));
    send_item(make_draw(8'd0, -4, -3, 1'b1));       // clipped top-left
    send_item(make_draw(8'd0, 316, 196, 1'b1));     // clipped bottom-right
    send_item(make_draw(8'd0, -8, 5, 1'b1));        // just left of the screen
    send_item(make_draw(8'd0, -1024, -1024, 1'b1)); // most negative position
    send_item(make_draw(8'd255, 1023, 1023, 1'b1)); // most positive position
    send_item(make_draw(8'd255, 100, 50, 1'b0));
    send_item(make_draw(8'd255, 312, 192, 1'b1));   // exactly in the corner
  endtask

  // Screen sizes from the smallest to oversized, including zero width and height
  task automatic test_screen_sizes();
    int dims [7][3] = '{'{1, 1, 0}, '{1024, 1024, 255}, '{2047, 2047, 8'hA5},
                        '{0, 200, 3}, '{320, 0, 9}, '{8, 8, 8'h5A}, '{1025, 1, 8'h80}};
    foreach (dims[i]) begin
      set_screen(dims[i][0], dims[i][1], dims[i][2]);
      repeat (18) random_draw();
    end
  endtask

  // Long output stall while the sender keeps offering draws back to back
  task automatic test_output_hold();
    set_screen(320, 200, 8'h0F);
    gaps_on = 1'b0;
    hold_reqs <= hold_reqs + 1;
    repeat (12)
      send_item(make_draw(drawable[$urandom_range(0, drawable.size() - 1)],
                          $urandom_range(0, 300), $urandom_range(0, 180), 1'b1));
    gaps_on = 1'b1;
  endtask

  // Whole glyph loads followed by a draw, stray row loads, draws and register changes
  task automatic test_random_traffic(int count);
    int                sent;
    int                next_cfg;
    int                sel;
    int                j;
    logic [ROW_W-1:0]  order [GLYPH_SIZE];
    logic [ROW_W-1:0]  tmp;
    logic [CODE_W-1:0] code;
    sent     = 0;
    next_cfg = 60;
    while (sent < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        code = CODE_W'($urandom);
        for (int r = 0; r < GLYPH_SIZE; r++) order[r] = ROW_W'(r);
        for (int r = GLYPH_SIZE - 1; r > 0; r--) begin
          j        = $urandom_range(0, r);
          tmp      = order[r];
          order[r] = order[j];
          order[j] = tmp;
        end
        for (int r = 0; r < GLYPH_SIZE; r++) send_item(make_load(code, order[r], random_row()));
        send_item(make_draw(code, pick_pos(scr_width, MAX_SCREEN_WIDTH),
                            pick_pos(scr_height, MAX_SCREEN_HEIGHT), 1'($urandom)));
        sent += GLYPH_SIZE + 1;
      end else if (sel < 27) begin
        send_item(make_load(CODE_W'($urandom), ROW_W'($urandom), random_row()));
        sent++;
      end else begin
        random_draw();
        sent++;
      end
      if (sent >= next_cfg) begin
        next_cfg += 60;
        set_screen(random_dim(), random_dim(), $urandom_range(0, 255));
      end
    end
  endtask

  function automatic int random_dim();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(1025, 2047);
      2:       return $urandom_range(1, 16);
      default: return $urandom_range(17, 1024);
    endcase
  endfunction

  initial begin
    rst_n                 <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.action          <= ACT_LOAD;
    in_ch.char_code       <= '0;
    in_ch.glyph_row       <= '0;
    in_ch.row_bits        <= '0;
    in_ch.pos_x           <= '0;
    in_ch.pos_y           <= '0;
    in_ch.fill_background <= 1'b0;
    scr_width  = RST_SCREEN_WIDTH;
    scr_height = RST_SCREEN_HEIGHT;
    ink_color  = RST_TEXT_COLOR;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_glyphs();
    test_screen_sizes();
    test_output_hold();
    test_random_traffic(270);

    wait_idle();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/gpb_pkg.sv
hw/rtl/gpb_ifs.sv
hw/rtl/gpb_cfg_regs.sv
hw/rtl/gpb_font_ram.sv
hw/rtl/gpb_draw_seq.sv
hw/rtl/glyph_to_pixel_blitter.sv
sim/glyph_to_pixel_blitter_tb.sv
